>>> rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg: shared constants and types for the gyro bias calibration block
// Calibration counts, divider reciprocal and the control structs that pass
// between the sequencing logic, the axis lanes and the top level.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int WARMUP_COUNT = 800;
    localparam int AVG_COUNT    = 800;

    localparam int RATE_W   = 16;
    localparam int CUTOFF_W = 15;
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 26;
    localparam int MAG_W    = 26;
    localparam int QUO_W    = 17;

    // Division by AVG_COUNT is a multiply by a rounded-up reciprocal.
    // The sum magnitude stays below 2^(15+L), which keeps the result exact.
    localparam int DIV_L    = $clog2(AVG_COUNT);
    localparam int DIV_K    = 15 + 2 * DIV_L;
    localparam int RECIP_W  = 17 + DIV_L;
    localparam int PROD_W   = MAG_W + RECIP_W;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_K) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [CNT_W-1:0] WARMUP_CNT = CNT_W'(WARMUP_COUNT);
    localparam logic [CNT_W:0]   END_CNT    = (CNT_W + 1)'(WARMUP_COUNT + AVG_COUNT);

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Per-item accumulation command, shared by all three lanes.
    typedef struct packed {
        logic accum;
        logic first;
        logic complete;
    } gbc_step_t;

    // Stage load enables of the lane pipeline.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } gbc_pipe_t;

endpackage

>>> rtl/gyro_bias_calibrate_deadband.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_deadband: three-axis gyro zero-offset calibration
// Warm-up, per-axis averaging into offsets, then offset correction with
// 16-bit saturation and a programmable deadband on every sample.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                       Direction
//  -------  --------------------------------------------  ---------
//  input    in_valid, in_stall, req_type, rate_x/y/z      in (stall out)
//  output   out_valid, out_stall, out_x/y/z, calibrated   out (stall in)
//  config   cfg_wr_en, cfg_wr_data (noise_cutoff)         in
//
//  One transfer is accepted per cycle while in_stall is low; each item's
//  result passes three lane stages and then the output register.
//  The depth is set by the reciprocal multiply of the offset divide,
//  which takes two stages, and the correction stage after it.
//  Reset (rst_n, asynchronous, active low) clears counts, sums, offsets and
//  all valid bits, and sets noise_cutoff to 4.
//  Each stage moves on when the one after it is empty or moving, so empty
//  stages fill while out_stall holds a result; in_stall rises only when
//  all four stages hold items.
//
module gyro_bias_calibrate_deadband (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [gbc_pkg::RATE_W-1:0]  rate_x,
    input  logic signed [gbc_pkg::RATE_W-1:0]  rate_y,
    input  logic signed [gbc_pkg::RATE_W-1:0]  rate_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [gbc_pkg::RATE_W-1:0]  out_x,
    output logic signed [gbc_pkg::RATE_W-1:0]  out_y,
    output logic signed [gbc_pkg::RATE_W-1:0]  out_z,
    output logic                               calibrated,
    input  logic                               cfg_wr_en,
    input  logic [gbc_pkg::CUTOFF_W-1:0]       cfg_wr_data
);
    import gbc_pkg::*;

    logic [CUTOFF_W-1:0] cutoff_reg;

    gbc_step_t step;
    gbc_pipe_t pipe;
    logic      take;
    logic      cal;
    logic      load_out;

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic cal1_reg, cal2_reg, cal3_reg;
    logic zero1_reg, zero2_reg, zero3_reg;

    logic signed [RATE_W-1:0] corr_x, corr_y, corr_z;
    logic signed [RATE_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                     cal_out_reg;

    // Stage enables ripple back from the output register.
    always_comb
    begin
        load_out = !vo_reg || !out_stall;
        pipe.en3 = !v3_reg || load_out;
        pipe.en2 = !v2_reg || pipe.en3;
        pipe.en1 = !v1_reg || pipe.en2;
    end

    assign in_stall = !pipe.en1;
    assign take     = in_valid && pipe.en1;

    gbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .req_type (req_type),
        .step     (step),
        .cal      (cal)
    );

    // One lane per axis; all three share the sequencer's command.
    gbc_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .rate   (rate_x),
        .step   (step),
        .pipe   (pipe),
        .cutoff (cutoff_reg),
        .corr   (corr_x)
    );

    gbc_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .rate   (rate_y),
        .step   (step),
        .pipe   (pipe),
        .cutoff (cutoff_reg),
        .corr   (corr_y)
    );

    gbc_lane u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .rate   (rate_z),
        .step   (step),
        .pipe   (pipe),
        .cutoff (cutoff_reg),
        .corr   (corr_z)
    );

    // Noise cutoff register and the valid bits that travel alongside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_W'(4);
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            vo_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cutoff_reg <= cfg_wr_data;
            end
            if (pipe.en1)
            begin
                v1_reg <= in_valid;
            end
            if (pipe.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (pipe.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (load_out)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    // Merging stage: the three lane results, the calibrated flag and the
    // zeroing of restart items come together in the output register.
    always_ff @(posedge clk)
    begin
        if (pipe.en1)
        begin
            cal1_reg  <= cal;
            zero1_reg <= (req_type == REQ_RESTART);
        end
        if (pipe.en2)
        begin
            cal2_reg  <= cal1_reg;
            zero2_reg <= zero1_reg;
        end
        if (pipe.en3)
        begin
            cal3_reg  <= cal2_reg;
            zero3_reg <= zero2_reg;
        end
        if (load_out)
        begin
            out_x_reg   <= zero3_reg ? '0 : corr_x;
            out_y_reg   <= zero3_reg ? '0 : corr_y;
            out_z_reg   <= zero3_reg ? '0 : corr_z;
            cal_out_reg <= cal3_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign calibrated = cal_out_reg;

    // Input is held off only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && vo_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // A result that is not taken stays in the output register.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(calibrated)))
        else $error("stalled result changed");

    // An accepted item reaches the first stage on the next edge.
    a_take_fill: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> v1_reg)
        else $error("accepted item lost at first stage");

endmodule

>>> rtl/gbc_ctrl.sv
// ----------------------------------------------------------------------------
// gbc_ctrl: calibration sequencer
// Counts warm-up and averaging samples and tells the lanes when to load,
// accumulate and finish the offset average.
// ----------------------------------------------------------------------------
module gbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              req_type,
    output gbc_pkg::gbc_step_t step,
    output logic              cal
);
    import gbc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W:0]   count_inc;
    logic             is_sample;

    assign is_sample = take && (req_type == REQ_SAMPLE);
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        step.accum    = is_sample && !done_reg && (count_reg >= WARMUP_CNT);
        step.first    = (count_reg == WARMUP_CNT);
        step.complete = step.accum && (count_inc >= END_CNT);
        count_next    = count_reg;
        done_next     = done_reg;
        if (take && (req_type == REQ_RESTART))
        begin
            count_next = '0;
            done_next  = 1'b0;
        end
        else if (is_sample && !done_reg)
        begin
            if (step.complete)
            begin
                count_next = '0;
                done_next  = 1'b1;
            end
            else
            begin
                count_next = count_inc[CNT_W-1:0];
            end
        end
        cal = (req_type == REQ_RESTART) ? 1'b0 : done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // The counter is cleared whenever the offsets become valid.
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg == '0))
        else $error("count not cleared while calibrated");

    // The counter never passes the end of the averaging window.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} < END_CNT))
        else $error("sample count out of range");

    // Finishing an average always sets the done flag on the next edge.
    a_complete_done: assert property (@(posedge clk) disable iff (!rst_n)
        step.complete |=> done_reg)
        else $error("average finished without done flag");

endmodule

>>> rtl/gbc_lane.sv
// ----------------------------------------------------------------------------
// gbc_lane: one axis of the calibration datapath
// Running sum, pipelined offset divide and offset correction with
// saturation and deadband.
// ----------------------------------------------------------------------------
module gbc_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [gbc_pkg::RATE_W-1:0] rate,
    input  gbc_pkg::gbc_step_t                step,
    input  gbc_pkg::gbc_pipe_t                pipe,
    input  logic [gbc_pkg::CUTOFF_W-1:0]      cutoff,
    output logic signed [gbc_pkg::RATE_W-1:0] corr
);
    import gbc_pkg::*;

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [RATE_W-1:0] off_reg;

    logic signed [RATE_W-1:0] s1_raw;
    logic signed [SUM_W-1:0]  s1_sum;
    logic                     s1_done;

    logic [MAG_W-1:0]         s1_mag;
    logic [PROD_W-1:0]        s2_prod;
    logic                     s2_neg;
    logic signed [RATE_W-1:0] s2_raw;
    logic                     s2_done;

    logic [QUO_W-1:0]         quo;
    logic signed [QUO_W-1:0]  off_new;
    logic signed [RATE_W-1:0] off_use;
    logic signed [RATE_W:0]   s3_diff;

    logic signed [RATE_W-1:0] sat;
    logic [RATE_W:0]          mag;

    assign sum_next = step.first ? SUM_W'(rate) : (sum_reg + SUM_W'(rate));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            off_reg <= '0;
            s1_done <= 1'b0;
            s2_done <= 1'b0;
        end
        else
        begin
            if (step.accum)
            begin
                sum_reg <= sum_next;
            end
            if (pipe.en1)
            begin
                s1_done <= step.complete;
            end
            if (pipe.en2)
            begin
                s2_done <= s1_done;
            end
            if (pipe.en3 && s2_done)
            begin
                off_reg <= off_new[RATE_W-1:0];
            end
        end
    end

    assign s1_mag = s1_sum[SUM_W-1] ? MAG_W'(-s1_sum) : MAG_W'(s1_sum);

    always_ff @(posedge clk)
    begin
        if (pipe.en1)
        begin
            s1_raw <= rate;
            s1_sum <= sum_next;
        end
        if (pipe.en2)
        begin
            s2_prod <= PROD_W'(s1_mag) * PROD_W'(RECIP);
            s2_neg  <= s1_sum[SUM_W-1];
            s2_raw  <= s1_raw;
        end
        if (pipe.en3)
        begin
            s3_diff <= (RATE_W + 1)'(s2_raw) - (RATE_W + 1)'(off_use);
        end
    end

    // The quotient of a finished average is the offset for its own item.
    always_comb
    begin
        quo     = s2_prod[DIV_K +: QUO_W];
        off_new = s2_neg ? -$signed(quo) : $signed(quo);
        off_use = s2_done ? off_new[RATE_W-1:0] : off_reg;
    end

    always_comb
    begin
        if (s3_diff[RATE_W] != s3_diff[RATE_W-1])
        begin
            sat = s3_diff[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
        end
        else
        begin
            sat = s3_diff[RATE_W-1:0];
        end
        mag  = sat[RATE_W-1] ? -(RATE_W + 1)'(sat) : (RATE_W + 1)'(sat);
        corr = (mag <= (RATE_W + 1)'(cutoff)) ? '0 : sat;
    end

endmodule

>>> tb/gyro_bias_calibrate_deadband_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_deadband_tb: self-checking bench for the gyro bias block
// Drives gyro samples and restart requests through the valid/stall input,
// predicts every result with a cycle-free software copy of the calibration,
// and compares each output transfer against it in order. Both channels idle
// and stall at random, and the noise cutoff is changed between phases.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_deadband_tb;

    import gbc_pkg::*;

    // A run with nothing accepted on either side for this many cycles is hung.
    // The longest legal quiet stretch is the forced sink hold-off plus a long
    // sink stall, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 160;

    typedef struct packed {
        logic [RATE_W-1:0] x;
        logic [RATE_W-1:0] y;
        logic [RATE_W-1:0] z;
        logic              cal;
    } rate_out_t;

    // One row of the directed table. Rows with known_res set carry a result
    // that is obvious by inspection; the others are checked by prediction.
    typedef struct packed {
        logic              req;
        logic [RATE_W-1:0] x;
        logic [RATE_W-1:0] y;
        logic [RATE_W-1:0] z;
        logic              known_res;
        rate_out_t         res;
    } stim_row_t;

    localparam rate_out_t ZERO_OUT = '{16'h0000, 16'h0000, 16'h0000, 1'b0};

    // All directed rows run during warm-up with offsets at zero and the
    // reset cutoff of 4, so a typed result is the sample with the deadband.
    localparam int DIR_ROWS = 18;
    localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{REQ_SAMPLE,  16'h0000, 16'h0000, 16'h0000, 1'b1, ZERO_OUT},
        // Exactly at the cutoff is zeroed, one above passes.
        '{REQ_SAMPLE,  16'h0004, 16'hFFFC, 16'h0005, 1'b1,
          '{16'h0000, 16'h0000, 16'h0005, 1'b0}},
        '{REQ_SAMPLE,  16'hFFFB, 16'h0003, 16'hFFFF, 1'b1,
          '{16'hFFFB, 16'h0000, 16'h0000, 1'b0}},
        // Full scale both ways; full-scale negative always passes.
        '{REQ_SAMPLE,  16'h7FFF, 16'h8000, 16'h0001, 1'b1,
          '{16'h7FFF, 16'h8000, 16'h0000, 1'b0}},
        '{REQ_SAMPLE,  16'h8001, 16'h7FFE, 16'hFFFC, 1'b1,
          '{16'h8001, 16'h7FFE, 16'h0000, 1'b0}},
        // A restart returns all zeros whatever its payload.
        '{REQ_RESTART, 16'h04D2, 16'hFB2E, 16'h004D, 1'b1, ZERO_OUT},
        '{REQ_SAMPLE,  16'h5555, 16'hAAAA, 16'h7FFF, 1'b1,
          '{16'h5555, 16'hAAAA, 16'h7FFF, 1'b0}},
        '{REQ_SAMPLE,  16'hAAAA, 16'h5555, 16'h8000, 1'b1,
          '{16'hAAAA, 16'h5555, 16'h8000, 1'b0}},
        '{REQ_SAMPLE,  16'h0064, 16'hFF9C, 16'h0006, 1'b1,
          '{16'h0064, 16'hFF9C, 16'h0006, 1'b0}},
        '{REQ_RESTART, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, ZERO_OUT},
        '{REQ_SAMPLE,  16'hFFFA, 16'h0002, 16'h3039, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'h3039, 16'hA460, 16'h0004, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'hFFFF, 16'h0001, 16'h8000, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'h7FFE, 16'h8001, 16'h0003, 1'b0, ZERO_OUT},
        '{REQ_RESTART, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'h0005, 16'hFFFB, 16'hFFFD, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'h0FF0, 16'hF00F, 16'h3C3C, 1'b0, ZERO_OUT},
        '{REQ_SAMPLE,  16'hC3C3, 16'hFFFC, 16'h0004, 1'b0, ZERO_OUT}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     req_type;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [RATE_W-1:0] out_x;
    logic signed [RATE_W-1:0] out_y;
    logic signed [RATE_W-1:0] out_z;
    logic                     calibrated;
    logic                     cfg_wr_en;
    logic [CUTOFF_W-1:0]      cfg_wr_data;

    // Software copy of the calibration state, advanced once per input
    // transfer in acceptance order.
    int  warm_count;
    bit  offsets_valid;
    int  axis_total [3];
    int  axis_bias [3];
    int  deadband_limit;

    // Results still owed by the block, oldest first.
    rate_out_t corrected_rates_q [$];

    int  rate_errors  = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    int  stall_left   = 0;
    bit  src_gaps_on  = 1'b1;
    bit  sink_gaps_on = 1'b1;

    gyro_bias_calibrate_deadband i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .calibrated  (calibrated),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offset subtraction with 16-bit saturation, then the deadband. A value
    // of -32768 has magnitude 32768 and so survives even the widest cutoff.
    function automatic logic [RATE_W-1:0] apply_deadband(int raw, int offs);
        int diff;
        int mag;
        diff = raw - offs;
        if (diff > 32767)
            diff = 32767;
        if (diff < -32768)
            diff = -32768;
        mag = (diff < 0) ? -diff : diff;
        if (mag <= deadband_limit)
            diff = 0;
        return RATE_W'(diff);
    endfunction

    // Advances the calibration by one item and returns the result it causes.
    // Warm-up samples are only counted; the first averaged sample loads the
    // sums, and the last one sets the offsets, which already apply to it.
    function automatic rate_out_t calibrate_and_correct(logic req, logic [RATE_W-1:0] rx,
                                                        logic [RATE_W-1:0] ry,
                                                        logic [RATE_W-1:0] rz);
        rate_out_t res;
        int        smp [3];
        bit        first_avg;
        int        a;
        res = ZERO_OUT;
        if (req == REQ_RESTART)
        begin
            // Offsets and sums survive a restart; only the sequencing clears.
            warm_count    = 0;
            offsets_valid = 1'b0;
            return res;
        end
        smp[0] = $signed(rx);
        smp[1] = $signed(ry);
        smp[2] = $signed(rz);
        if (!offsets_valid)
        begin
            if (warm_count < WARMUP_COUNT)
                warm_count++;
            else
            begin
                first_avg = (warm_count == WARMUP_COUNT);
                for (a = 0; a < 3; a++)
                    axis_total[a] = first_avg ? smp[a] : axis_total[a] + smp[a];
                warm_count++;
                if (warm_count >= WARMUP_COUNT + AVG_COUNT)
                begin
                    // Integer division truncates toward zero, as required.
                    for (a = 0; a < 3; a++)
                        axis_bias[a] = axis_total[a] / AVG_COUNT;
                    offsets_valid = 1'b1;
                    warm_count    = 0;
                end
            end
        end
        res.x   = apply_deadband(smp[0], axis_bias[0]);
        res.y   = apply_deadband(smp[1], axis_bias[1]);
        res.z   = apply_deadband(smp[2], axis_bias[2]);
        res.cal = offsets_valid;
        return res;
    endfunction

    // Random sample for one axis: mostly a steady bias with a little noise,
    // which is what a resting sensor produces and what makes the averaged
    // offset land somewhere meaningful. The rest sits right on the deadband
    // edge around the current offset, at full scale, or anywhere at all.
    function automatic logic [RATE_W-1:0] pick_rate(int bias, int offs);
        int v;
        int edge_dist;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            v = bias + int'($urandom_range(0, 80)) - 40;
        else if (roll < 70)
        begin
            edge_dist = deadband_limit + int'($urandom_range(0, 2)) - 1;
            v = ($urandom_range(0, 1) == 1) ? offs + edge_dist : offs - edge_dist;
        end
        else if (roll < 80)
        begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = -32767;
                3: v = 0;
                default: v = -1;
            endcase
        end
        else
            v = int'($signed(RATE_W'($urandom())));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return RATE_W'(v);
    endfunction

    // Sender gap: usually none, sometimes short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (!src_gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one item and holds it until the block takes it. On acceptance
    // the prediction is made and queued, or the typed result is queued for
    // directed rows (the state is still advanced for those).
    task automatic send_item(input logic req, input logic [RATE_W-1:0] x,
                             input logic [RATE_W-1:0] y, input logic [RATE_W-1:0] z,
                             input logic known_res, input rate_out_t typed_res);
        int        gap;
        rate_out_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rate_x   <= x;
        rate_y   <= y;
        rate_z   <= z;
        do
            @(posedge clk);
        while (in_stall);
        pred = calibrate_and_correct(req, x, y, z);
        corrected_rates_q.push_back(known_res ? typed_res : pred);
    endtask

    // A stretch of samples around a fresh per-axis bias. restart_permille
    // sprinkles restarts in, which breaks calibration runs part way through.
    task automatic run_samples(input int count, input int restart_permille);
        int                bias [3];
        logic [RATE_W-1:0] r [3];
        int                i;
        int                a;
        for (a = 0; a < 3; a++)
            bias[a] = int'($urandom_range(0, 65535)) - 32768;
        for (i = 0; i < count; i++)
        begin
            if (int'($urandom_range(0, 999)) < restart_permille)
                send_item(REQ_RESTART, RATE_W'($urandom()), RATE_W'($urandom()),
                          RATE_W'($urandom()), 1'b0, ZERO_OUT);
            else
            begin
                for (a = 0; a < 3; a++)
                    r[a] = pick_rate(bias[a], axis_bias[a]);
                send_item(REQ_SAMPLE, r[0], r[1], r[2], 1'b0, ZERO_OUT);
            end
        end
    endtask

    // The cutoff changes only with the pipeline drained; the extra cycles
    // cover the four-stage latency quoted for the block.
    task automatic write_cutoff(input logic [CUTOFF_W-1:0] value);
        in_valid <= 1'b0;
        while (corrected_rates_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        deadband_limit = int'(value);
    endtask

    // Calibration restarts from a known point, then a full warm-up and
    // averaging run, then some items with the new offsets in force.
    task automatic full_calibration(input int tail_items);
        send_item(REQ_RESTART, RATE_W'($urandom()), RATE_W'($urandom()),
                  RATE_W'($urandom()), 1'b0, ZERO_OUT);
        run_samples(WARMUP_COUNT + AVG_COUNT + tail_items, 0);
    endtask

    // Output side: checks every result transfer against the oldest
    // expectation, then decides the stall for the next cycle. Values are
    // sampled as they stood at the clock edge.
    always @(posedge clk)
    begin : sink_side
        rate_out_t want;
        rate_out_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{out_x, out_y, out_z, calibrated};
                results_seen++;
                if (corrected_rates_q.size() == 0)
                begin
                    rate_errors++;
                    if (rate_errors <= 10)
                        $display("unexpected result x=%0d y=%0d z=%0d cal=%0d",
                                 $signed(got.x), $signed(got.y), $signed(got.z), got.cal);
                end
                else
                begin
                    want = corrected_rates_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.cal !== want.cal)
                    begin
                        rate_errors++;
                        if (rate_errors <= 10)
                            $display("result %0d: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     results_seen, $signed(want.x), $signed(want.y),
                                     $signed(want.z), want.cal, $signed(got.x),
                                     $signed(got.y), $signed(got.z), got.cal);
                    end
                end
                // Twice in the run the sink holds off long enough for all
                // four stages to fill and the input to back up.
                if (results_seen == 400 || results_seen == 1720)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (sink_gaps_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                         : $urandom_range(1, 3);
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int row;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_SAMPLE;
        rate_x      = '0;
        rate_y      = '0;
        rate_z      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        warm_count     = 0;
        offsets_valid  = 1'b0;
        deadband_limit = 4;
        for (row = 0; row < 3; row++)
        begin
            axis_total[row] = 0;
            axis_bias[row]  = 0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset cutoff.
        for (row = 0; row < DIR_ROWS; row++)
            send_item(DIR_TABLE[row].req, DIR_TABLE[row].x, DIR_TABLE[row].y,
                      DIR_TABLE[row].z, DIR_TABLE[row].known_res, DIR_TABLE[row].res);

        // No deadband: one complete calibration, with the first hold-off
        // landing in the middle of it.
        write_cutoff('0);
        full_calibration(40);

        // Widest deadband and no idling on either side: only full-scale
        // negative differences get through.
        write_cutoff(15'h7FFF);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        run_samples(40, 50);
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;

        // A restart followed by warm-up samples: the old offsets stay in
        // force while the new run is still counting.
        write_cutoff(CUTOFF_W'($urandom_range(1, 200)));
        send_item(REQ_RESTART, '0, '0, '0, 1'b0, ZERO_OUT);
        run_samples(60, 0);

        // Noise with frequent restarts at an arbitrary cutoff, then back to
        // the reset value.
        write_cutoff(CUTOFF_W'($urandom_range(0, 32767)));
        run_samples(40, 80);
        write_cutoff(CUTOFF_W'(4));
        run_samples(30, 30);

        in_valid <= 1'b0;
        while (corrected_rates_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (rate_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
